>>> hdl/assert_macros.svh
// assertion macros used by the sequencer
// no dependencies; clocked on clk, disabled while rst_n is low
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold at every clock edge
`define MMM_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// same-cycle implication
`define MMM_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define MMM_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hdl/mmm_pkg.sv
// types and constants of the mdio management master
// no dependencies; used by every module of the block
package mmm_pkg;

    // opcodes of an input beat
    localparam logic [1:0] OP_TICK  = 2'd0;
    localparam logic [1:0] OP_READ  = 2'd1;
    localparam logic [1:0] OP_WRITE = 2'd2;

    // frame fields
    localparam int          PREAMBLE_BITS = 32;
    localparam int          BIT_CNT_W     = 6;
    localparam logic [3:0]  HDR_READ      = 4'b0110;   // start 01, opcode 10
    localparam logic [3:0]  HDR_WRITE     = 4'b0101;   // start 01, opcode 01
    localparam logic [1:0]  TA_WRITE      = 2'b10;
    localparam int          HDR_BITS_RD   = 14;
    localparam int          HDR_BITS_WR   = 32;
    localparam int          DATA_BITS     = 16;
    localparam logic [7:0]  HALF_RESET    = 8'd1;

    // classified beat handed from front to back
    typedef struct packed {
        logic        is_cmd;
        logic        is_read;
        logic [31:0] send;
        logic        din;
    } cmd_t;

    // result beat
    typedef struct packed {
        logic        mdc;
        logic        mdio_out;
        logic        mdio_oe;
        logic        busy;
        logic        done;
        logic [15:0] read_data;
        logic        rejected;
    } res_t;

endpackage

>>> hdl/mmm_cmd_queue.sv
// front end: classifies input beats and queues them for the sequencer
// depends on mmm_pkg
module mmm_cmd_queue (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    output logic               full,
    input  logic [1:0]         opcode,
    input  logic [4:0]         phy_id,
    input  logic [4:0]         reg_addr,
    input  logic [15:0]        write_data,
    input  logic               mdio_in,
    output logic               cmd_valid,
    output mmm_pkg::cmd_t      cmd,
    input  logic               cmd_pop
);

    mmm_pkg::cmd_t cls;
    mmm_pkg::cmd_t slot_reg [2];
    logic          wr_ptr_reg, wr_ptr_next;
    logic          rd_ptr_reg, rd_ptr_next;
    logic [1:0]    count_reg, count_next;
    logic          do_push, do_pop;

    // classify opcode and build the frame word
    always_comb
    begin
        cls.is_cmd  = (opcode == mmm_pkg::OP_READ) || (opcode == mmm_pkg::OP_WRITE);
        cls.is_read = (opcode == mmm_pkg::OP_READ);
        cls.din     = mdio_in;
        if (cls.is_read)
        begin
            cls.send = {mmm_pkg::HDR_READ, phy_id, reg_addr, 18'd0};
        end
        else
        begin
            cls.send = {mmm_pkg::HDR_WRITE, phy_id, reg_addr, mmm_pkg::TA_WRITE,
                        write_data};
        end
    end

    assign full      = (count_reg == 2'd2);
    assign cmd_valid = (count_reg != 2'd0);
    assign cmd       = slot_reg[rd_ptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = cmd_pop && cmd_valid;

    // pointer and count update
    always_comb
    begin
        wr_ptr_next = do_push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, do_push} - {1'b0, do_pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // queue storage
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= cls;
        end
    end

endmodule

>>> hdl/mmm_sequencer.sv
// back end: mdio frame sequencer, one classified beat per cycle while one is queued and the result queue has room
// depends on mmm_pkg and assert_macros.svh
`include "assert_macros.svh"

module mmm_sequencer (
    input  logic               clk,
    input  logic               rst_n,
    input  logic [7:0]         half_period,
    input  logic               cmd_valid,
    input  mmm_pkg::cmd_t      cmd,
    output logic               cmd_pop,
    input  logic               res_room,
    output logic               res_push,
    output mmm_pkg::res_t      res
);

    localparam logic [2:0] PH_IDLE     = 3'd0;
    localparam logic [2:0] PH_PREAMBLE = 3'd1;
    localparam logic [2:0] PH_SHIFT    = 3'd2;
    localparam logic [2:0] PH_TURN     = 3'd3;
    localparam logic [2:0] PH_READ     = 3'd4;
    localparam logic [2:0] PH_END      = 3'd5;

    localparam int BW = mmm_pkg::BIT_CNT_W;

    logic [2:0]    phase_reg, phase_next;
    logic [BW-1:0] bitc_reg, bitc_next;
    logic [31:0]   send_reg, send_next;
    logic [15:0]   recv_reg, recv_next;
    logic [15:0]   last_reg, last_next;
    logic          clk_reg, clk_next;
    logic          oe_reg, oe_next;
    logic          rd_reg, rd_next;
    logic [7:0]    tick_reg, tick_next;

    logic          advance;
    logic          start;
    logic          done;
    logic [7:0]    hp;
    logic [BW:0]   n;
    logic [8:0]    tick_inc;

    assign advance  = cmd_valid && res_room;
    assign cmd_pop  = advance;
    assign res_push = advance;
    assign start    = cmd.is_cmd && (phase_reg == PH_IDLE);
    assign hp       = (half_period == 8'd0) ? 8'd1 : half_period;
    assign n        = {1'b0, bitc_reg} + {{BW{1'b0}}, 1'b1};
    assign tick_inc = {1'b0, tick_reg} + 9'd1;

    // frame state update for one beat
    always_comb
    begin
        phase_next = phase_reg;
        bitc_next  = bitc_reg;
        send_next  = send_reg;
        recv_next  = recv_reg;
        last_next  = last_reg;
        clk_next   = clk_reg;
        oe_next    = oe_reg;
        rd_next    = rd_reg;
        tick_next  = tick_reg;
        done       = 1'b0;
        if (start)
        begin
            rd_next    = cmd.is_read;
            send_next  = cmd.send;
            phase_next = PH_PREAMBLE;
            bitc_next  = '0;
            tick_next  = 8'd0;
            clk_next   = 1'b0;
            oe_next    = 1'b1;
            recv_next  = 16'd0;
        end
        else if (phase_reg != PH_IDLE)
        begin
            if (tick_inc < {1'b0, hp})
            begin
                tick_next = tick_inc[7:0];
            end
            else
            begin
                tick_next = 8'd0;
                if (!clk_reg)
                begin
                    // rising half: sample read data
                    if (phase_reg == PH_READ)
                    begin
                        recv_next = {recv_reg[14:0], cmd.din};
                    end
                    clk_next = 1'b1;
                end
                else
                begin
                    // falling half: end of bit slot
                    clk_next = 1'b0;
                    case (phase_reg)
                        PH_PREAMBLE:
                        begin
                            if (n >= (BW+1)'(mmm_pkg::PREAMBLE_BITS))
                            begin
                                phase_next = PH_SHIFT;
                                bitc_next  = '0;
                            end
                            else
                            begin
                                bitc_next = n[BW-1:0];
                            end
                        end
                        PH_SHIFT:
                        begin
                            send_next = {send_reg[30:0], 1'b0};
                            if (n >= (rd_reg ? (BW+1)'(mmm_pkg::HDR_BITS_RD)
                                             : (BW+1)'(mmm_pkg::HDR_BITS_WR)))
                            begin
                                bitc_next = '0;
                                if (rd_reg)
                                begin
                                    phase_next = PH_TURN;
                                    oe_next    = 1'b0;
                                end
                                else
                                begin
                                    phase_next = PH_END;
                                end
                            end
                            else
                            begin
                                bitc_next = n[BW-1:0];
                            end
                        end
                        PH_TURN:
                        begin
                            phase_next = PH_READ;
                            bitc_next  = '0;
                        end
                        PH_READ:
                        begin
                            if (n >= (BW+1)'(mmm_pkg::DATA_BITS))
                            begin
                                last_next  = recv_reg;
                                phase_next = PH_END;
                                bitc_next  = '0;
                                oe_next    = 1'b1;
                            end
                            else
                            begin
                                bitc_next = n[BW-1:0];
                            end
                        end
                        PH_END:
                        begin
                            phase_next = PH_IDLE;
                            bitc_next  = '0;
                            oe_next    = 1'b1;
                            done       = 1'b1;
                        end
                        default:
                        begin
                            phase_next = PH_IDLE;
                            bitc_next  = '0;
                            oe_next    = 1'b1;
                        end
                    endcase
                end
            end
        end
    end

    // result beat from the state after this beat
    always_comb
    begin
        res.mdc       = clk_next;
        res.mdio_oe   = oe_next;
        if (!oe_next)
        begin
            res.mdio_out = 1'b0;
        end
        else if (phase_next == PH_SHIFT)
        begin
            res.mdio_out = send_next[31];
        end
        else
        begin
            res.mdio_out = 1'b1;
        end
        res.busy      = (phase_next != PH_IDLE);
        res.done      = done;
        res.read_data = last_next;
        res.rejected  = cmd.is_cmd && !start;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            bitc_reg  <= '0;
            send_reg  <= 32'd0;
            recv_reg  <= 16'd0;
            last_reg  <= 16'd0;
            clk_reg   <= 1'b0;
            oe_reg    <= 1'b1;
            rd_reg    <= 1'b0;
            tick_reg  <= 8'd0;
        end
        else if (advance)
        begin
            phase_reg <= phase_next;
            bitc_reg  <= bitc_next;
            send_reg  <= send_next;
            recv_reg  <= recv_next;
            last_reg  <= last_next;
            clk_reg   <= clk_next;
            oe_reg    <= oe_next;
            rd_reg    <= rd_next;
            tick_reg  <= tick_next;
        end
    end

    // checks
    `MMM_ASSERT_IMP(idle_quiet_a, phase_reg == PH_IDLE,
        !clk_reg && oe_reg && (tick_reg == 8'd0), "idle sequencer not at rest")
    `MMM_ASSERT_IMP(release_phase_a, !oe_reg,
        (phase_reg == PH_TURN) || (phase_reg == PH_READ), "mdio released outside read")
    `MMM_ASSERT_IMP(read_count_a, phase_reg == PH_READ,
        bitc_reg < BW'(mmm_pkg::DATA_BITS), "read bit count overrun")
    `MMM_ASSERT_NXT(done_idle_a, advance && done,
        phase_reg == PH_IDLE, "frame done but sequencer still busy")

endmodule

>>> hdl/mmm_result_queue.sv
// result queue between the sequencer and the result port
// depends on mmm_pkg
module mmm_result_queue (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               res_push,
    input  mmm_pkg::res_t      res_in,
    output logic               res_room,
    output logic               empty,
    input  logic               pop,
    output mmm_pkg::res_t      res_out
);

    mmm_pkg::res_t slot_reg [2];
    logic          wr_ptr_reg, wr_ptr_next;
    logic          rd_ptr_reg, rd_ptr_next;
    logic [1:0]    count_reg, count_next;
    logic          do_push, do_pop;

    assign res_room = (count_reg != 2'd2);
    assign empty    = (count_reg == 2'd0);
    assign res_out  = slot_reg[rd_ptr_reg];
    assign do_push  = res_push && res_room;
    assign do_pop   = pop && !empty;

    // pointer and count update
    always_comb
    begin
        wr_ptr_next = do_push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, do_push} - {1'b0, do_pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // queue storage
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= res_in;
        end
    end

endmodule

>>> hdl/mdio_management_master.sv
// path: a beat waits in the command queue until the sequencer takes it; its result is
// registered in the result queue and shows on the result ports until it is popped
// throughput: one beat per cycle; the sequencer takes one queued beat each cycle
// that the result queue has room; each beat taken during a frame moves mdc by one tick
// reset: rst_n low clears both queues, idles the sequencer with mdio enabled,
// and sets the half period to one tick
module mdio_management_master (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic [1:0]  opcode,
    input  logic [4:0]  phy_id,
    input  logic [4:0]  reg_addr,
    input  logic [15:0] write_data,
    input  logic        mdio_in,
    output logic        empty,
    input  logic        pop,
    output logic        mdc,
    output logic        mdio_out,
    output logic        mdio_oe,
    output logic        busy_res,
    output logic        done_res,
    output logic [15:0] read_data,
    output logic        cmd_rejected,
    input  logic        cfg_we,
    input  logic [7:0]  cfg_wdata
);

    logic [7:0]    half_reg, half_next;
    logic          cmd_valid, cmd_pop;
    mmm_pkg::cmd_t cmd;
    logic          res_room, res_push;
    mmm_pkg::res_t res_in, res_out;

    // half period register
    assign half_next = cfg_we ? cfg_wdata : half_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            half_reg <= mmm_pkg::HALF_RESET;
        end
        else
        begin
            half_reg <= half_next;
        end
    end

    mmm_cmd_queue u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .full       (full),
        .opcode     (opcode),
        .phy_id     (phy_id),
        .reg_addr   (reg_addr),
        .write_data (write_data),
        .mdio_in    (mdio_in),
        .cmd_valid  (cmd_valid),
        .cmd        (cmd),
        .cmd_pop    (cmd_pop)
    );

    mmm_sequencer u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .half_period (half_reg),
        .cmd_valid   (cmd_valid),
        .cmd         (cmd),
        .cmd_pop     (cmd_pop),
        .res_room    (res_room),
        .res_push    (res_push),
        .res         (res_in)
    );

    mmm_result_queue u_out (
        .clk      (clk),
        .rst_n    (rst_n),
        .res_push (res_push),
        .res_in   (res_in),
        .res_room (res_room),
        .empty    (empty),
        .pop      (pop),
        .res_out  (res_out)
    );

    // result fields
    assign mdc          = res_out.mdc;
    assign mdio_out     = res_out.mdio_out;
    assign mdio_oe      = res_out.mdio_oe;
    assign busy_res     = res_out.busy;
    assign done_res     = res_out.done;
    assign read_data    = res_out.read_data;
    assign cmd_rejected = res_out.rejected;

endmodule
